/* rtl/alcc_pkg.sv */
`timescale 1ns / 1ps
package alcc_pkg;

	localparam int NUM_OBS     = 16;
	localparam int OBS_IDX_W   = 4;
	localparam int OBS_CNT_W   = 5;
	localparam int COORD_W     = 16;
	localparam int LEN_W       = 15;
	localparam int ANG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 15;
	localparam int TRIG_W      = 18;
	localparam int Z_W         = 32;
	localparam int PROD_W      = 40;
	localparam int CTR_W       = 34;
	localparam int RAD_W       = 26;
	localparam int SQ_W        = 52;
	localparam int STEP_W      = 4;
	localparam int IN_DATA_W   = 104;
	localparam int OUT_DATA_W  = 8;

	localparam logic [TRIG_W-1:0] CORDIC_START = 18'd9949;

	localparam logic [CFG_IDX_W-1:0] REG_LINK1  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK2  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK3  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic                 load_query;
		logic                 cordic_init;
		logic                 cordic_step;
		logic                 mul;
		logic                 centre;
		logic                 adv;
		logic                 issue;
		logic                 finish;
		logic [STEP_W-1:0]    step;
		logic [1:0]           link;
		logic [1:0]           kidx;
		logic [OBS_IDX_W-1:0] obs;
	} cmd_t;

	typedef struct packed {
		logic [OBS_CNT_W-1:0] n_obs;
	} sts_t;

	function automatic logic [Z_W-1:0] arc_angle(input logic [STEP_W-1:0] i);
		logic [Z_W-1:0] a;
		case (i)
			4'd0:    a = 32'h20000000;
			4'd1:    a = 32'h12E4051E;
			4'd2:    a = 32'h09FB385B;
			4'd3:    a = 32'h051111D4;
			4'd4:    a = 32'h028B0D43;
			4'd5:    a = 32'h0145D7E1;
			4'd6:    a = 32'h00A2F61E;
			4'd7:    a = 32'h00517C55;
			4'd8:    a = 32'h0028BE53;
			4'd9:    a = 32'h00145F2F;
			4'd10:   a = 32'h000A2F98;
			4'd11:   a = 32'h000517CC;
			4'd12:   a = 32'h00028BE6;
			4'd13:   a = 32'h000145F3;
			4'd14:   a = 32'h0000A2FA;
			default: a = 32'h0000517D;
		endcase
		return a;
	endfunction

endpackage

/* rtl/alcc_ctrl.sv */
`timescale 1ns / 1ps
module alcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_go,
	input  logic          out_free,
	input  alcc_pkg::sts_t sts,
	output alcc_pkg::cmd_t cmd,
	output logic          idle,
	output logic          out_set
);
	import alcc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CINIT = 4'd1;
	localparam logic [3:0] S_CSTEP = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_CENT  = 4'd4;
	localparam logic [3:0] S_ISSUE = 4'd5;
	localparam logic [3:0] S_ADV   = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [1:0]           link_q;
	logic [1:0]           k_q;
	logic [OBS_CNT_W-1:0] j_q;
	logic                 last_obs;

	assign idle     = (state_q == S_IDLE);
	assign last_obs = ((j_q + 5'd1) >= sts.n_obs);

	always_comb begin
		cmd             = '0;
		cmd.load_query  = idle && in_go;
		cmd.cordic_init = (state_q == S_CINIT);
		cmd.cordic_step = (state_q == S_CSTEP);
		cmd.mul         = (state_q == S_MUL);
		cmd.centre      = (state_q == S_CENT);
		cmd.adv         = (state_q == S_ADV);
		cmd.issue       = (state_q == S_ISSUE) && (j_q < sts.n_obs);
		cmd.finish      = (state_q == S_DONE) && out_free;
		cmd.step        = step_q;
		cmd.link        = link_q;
		cmd.kidx        = k_q;
		cmd.obs         = j_q[OBS_IDX_W-1:0];
		out_set         = cmd.finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			link_q  <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						link_q  <= '0;
						state_q <= S_CINIT;
					end
				end
				S_CINIT: begin
					step_q  <= '0;
					state_q <= S_CSTEP;
				end
				S_CSTEP: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= S_MUL;
				end
				S_MUL: begin
					k_q     <= '0;
					state_q <= S_CENT;
				end
				S_CENT: begin
					j_q     <= '0;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					j_q <= j_q + 5'd1;
					if (last_obs) begin
						if (k_q != 2'd2) begin
							k_q     <= k_q + 2'd1;
							state_q <= S_CENT;
						end else if (link_q != 2'd2) begin
							state_q <= S_ADV;
						end else begin
							step_q  <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_ADV: begin
					link_q  <= link_q + 2'd1;
					state_q <= S_CINIT;
				end
				S_DRAIN: begin
					// compare pipeline is three deep
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/alcc_dp.sv */
`timescale 1ns / 1ps
module alcc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alcc_pkg::cmd_t                cmd,
	output alcc_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [alcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [alcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          obs_we,
	input  logic [alcc_pkg::OBS_IDX_W-1:0]  obs_idx,
	input  logic [alcc_pkg::COORD_W-1:0]    obs_x,
	input  logic [alcc_pkg::COORD_W-1:0]    obs_y,
	input  logic [alcc_pkg::LEN_W-1:0]      obs_rad,
	input  logic [alcc_pkg::ANG_W-1:0]      ang1,
	input  logic [alcc_pkg::ANG_W-1:0]      ang2,
	input  logic [alcc_pkg::ANG_W-1:0]      ang3,
	output logic                          collision
);
	import alcc_pkg::*;

	logic [LEN_W-1:0]     len_q [3];
	logic [LEN_W-1:0]     margin_q;
	logic [OBS_CNT_W-1:0] count_q;

	logic [COORD_W-1:0] ox_q [NUM_OBS];
	logic [COORD_W-1:0] oy_q [NUM_OBS];
	logic [LEN_W-1:0]   orad_q [NUM_OBS];

	logic [ANG_W-1:0]         ang_q [3];
	logic [1:0]               quad_q;
	logic signed [TRIG_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [PROD_W-1:0] px_q, py_q, bx_q, by_q;
	logic signed [CTR_W-1:0]  cx_q, cy_q;
	logic                     hit_q;

	// compare pipeline
	logic                     v_s1, v_s2;
	logic [RAD_W-1:0]         ux_s1, uy_s1, r_s1;
	logic                     far_s1, far_s2;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, rr_s2;

	logic signed [TRIG_W-1:0] tx, ty, c_v, s_v;
	logic signed [Z_W-1:0]    arc;
	logic signed [PROD_W-1:0] kpx, kpy, sumx, sumy, oxs, oys, dx, dy;
	logic [PROD_W-1:0]        adx, ady;
	logic [RAD_W-1:0]         r_v;
	logic [LEN_W-1:0]         len_l;
	logic [ANG_W-1:0]         ang_l;

	assign sts.n_obs = (count_q > OBS_CNT_W'(NUM_OBS)) ? OBS_CNT_W'(NUM_OBS) : count_q;
	assign len_l     = len_q[cmd.link];
	assign ang_l     = ang_q[cmd.link];

	always_comb begin
		tx  = y_q >>> cmd.step;
		ty  = x_q >>> cmd.step;
		arc = signed'(arc_angle(cmd.step));
		case (quad_q)
			2'd0:    begin c_v = x_q;  s_v = y_q;  end
			2'd1:    begin c_v = -y_q; s_v = x_q;  end
			2'd2:    begin c_v = -x_q; s_v = -y_q; end
			default: begin c_v = y_q;  s_v = -x_q; end
		endcase
		case (cmd.kidx)
			2'd0:    begin kpx = px_q;                    kpy = py_q;                    end
			2'd1:    begin kpx = px_q + (px_q <<< 1);     kpy = py_q + (py_q <<< 1);     end
			default: begin kpx = px_q + (px_q <<< 2);     kpy = py_q + (py_q <<< 2);     end
		endcase
		sumx = bx_q + kpx;
		sumy = by_q + kpy;
		oxs  = PROD_W'(signed'(ox_q[cmd.obs]));
		oys  = PROD_W'(signed'(oy_q[cmd.obs]));
		dx   = PROD_W'(cx_q) - ((oxs <<< 8) + (oxs <<< 7));
		dy   = PROD_W'(cy_q) - ((oys <<< 8) + (oys <<< 7));
		adx  = dx[PROD_W-1] ? PROD_W'(-dx) : PROD_W'(dx);
		ady  = dy[PROD_W-1] ? PROD_W'(-dy) : PROD_W'(dy);
		r_v  = RAD_W'((RAD_W'(len_l) + RAD_W'(6) * (RAD_W'(orad_q[cmd.obs]) + RAD_W'(margin_q)))
			<< 6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= '0;
			len_q[1] <= '0;
			len_q[2] <= '0;
			margin_q <= '0;
			count_q  <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LINK1:  len_q[0] <= cfg_data;
					REG_LINK2:  len_q[1] <= cfg_data;
					REG_LINK3:  len_q[2] <= cfg_data;
					REG_MARGIN: margin_q <= cfg_data;
					REG_COUNT:  count_q  <= cfg_data[OBS_CNT_W-1:0];
					default:    ;
				endcase
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.load_query)
				hit_q <= 1'b0;
			else if (v_s2 && !far_s2 && ({1'b0, sqx_s2} + {1'b0, sqy_s2} < {1'b0, rr_s2}))
				hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (obs_we) begin
			ox_q[obs_idx]   <= obs_x;
			oy_q[obs_idx]   <= obs_y;
			orad_q[obs_idx] <= obs_rad;
		end
		if (cmd.load_query) begin
			ang_q[0] <= ang1;
			ang_q[1] <= ang1 + ang2;
			ang_q[2] <= ang1 + ang2 + ang3;
			bx_q     <= '0;
			by_q     <= '0;
		end
		if (cmd.cordic_init) begin
			quad_q <= ang_l[15:14];
			z_q    <= signed'({2'b00, ang_l[13:0], 16'h0000});
			x_q    <= signed'(CORDIC_START);
			y_q    <= '0;
		end
		if (cmd.cordic_step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - tx;
				y_q <= y_q + ty;
				z_q <= z_q - arc;
			end else begin
				x_q <= x_q + tx;
				y_q <= y_q - ty;
				z_q <= z_q + arc;
			end
		end
		if (cmd.mul) begin
			px_q <= PROD_W'(signed'({1'b0, len_l}) * c_v);
			py_q <= PROD_W'(signed'({1'b0, len_l}) * s_v);
		end
		if (cmd.centre) begin
			cx_q <= CTR_W'(sumx >>> 8);
			cy_q <= CTR_W'(sumy >>> 8);
		end
		if (cmd.adv) begin
			bx_q <= bx_q + (px_q <<< 2) + (px_q <<< 1);
			by_q <= by_q + (py_q <<< 2) + (py_q <<< 1);
		end
		if (cmd.issue) begin
			far_s1 <= (adx >= PROD_W'(r_v)) || (ady >= PROD_W'(r_v));
			ux_s1  <= adx[RAD_W-1:0];
			uy_s1  <= ady[RAD_W-1:0];
			r_s1   <= r_v;
		end
		far_s2 <= far_s1;
		sqx_s2 <= ux_s1 * ux_s1;
		sqy_s2 <= uy_s1 * uy_s1;
		rr_s2  <= r_s1 * r_s1;
		if (cmd.finish)
			collision <= hit_q;
	end

endmodule

/* rtl/arm_link_collision_check_unit.sv */
`timescale 1ns / 1ps
// Planar three-link arm collision check. tuser bit 0 selects the item kind: 0 loads an
// obstacle table entry (no result), 1 queries three joint angles and returns one transfer
// carrying the collision flag. A query runs a 16-step CORDIC per link and then streams
// the checked obstacles through a three-stage compare for each of the nine circles; a
// query with no checked obstacles takes as long as a query with one. The single shared
// CORDIC and the one-obstacle-per-cycle compare set the query time. Write configuration
// only while idle.
module arm_link_collision_check_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// joint1_angle, joint2_angle, joint3_angle, obstacle_index, obstacle_x, obstacle_y,
	// obstacle_radius
	input  logic [alcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,   // mode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [alcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // collision
	input  logic                            cfg_we,
	input  logic [alcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [alcc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import alcc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle, out_set, acc, collision, out_valid_q;

	assign s_axis_tready = idle;
	assign acc           = s_axis_tvalid && idle;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, collision};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_set)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	alcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_go    (acc && (s_axis_tuser == MODE_QUERY)),
		.out_free (!out_valid_q || m_axis_tready),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle),
		.out_set  (out_set)
	);

	alcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.obs_we    (acc && (s_axis_tuser == MODE_LOAD)),
		.obs_idx   (s_axis_tdata[51:48]),
		.obs_x     (s_axis_tdata[67:52]),
		.obs_y     (s_axis_tdata[83:68]),
		.obs_rad   (s_axis_tdata[98:84]),
		.ang1      (s_axis_tdata[15:0]),
		.ang2      (s_axis_tdata[31:16]),
		.ang3      (s_axis_tdata[47:32]),
		.collision (collision)
	);

endmodule
